// ===== design/upc_pkg.sv =====
// shared types, character constants and class functions of the url percent codec
package upc_pkg;

  localparam int unsigned SeqLen = 7;

  localparam logic [7:0] CHR_PCT     = 8'h25;
  localparam logic [7:0] CHR_0       = 8'h30;
  localparam logic [7:0] CHR_2       = 8'h32;
  localparam logic [7:0] CHR_5       = 8'h35;
  localparam logic [7:0] CHR_9       = 8'h39;
  localparam logic [7:0] CHR_A       = 8'h41;
  localparam logic [7:0] CHR_F       = 8'h46;
  localparam logic [7:0] CHR_LA      = 8'h61;
  localparam logic [7:0] CHR_LF      = 8'h66;
  localparam logic [7:0] NIBBLE_MASK = 8'h0f;
  localparam logic [7:0] HEX_TEN     = 8'd10;

  localparam logic [1:0] CLS_R = 2'b01;
  localparam logic [1:0] CLS_U = 2'b10;

  // class of bytes 0..127: bit 0 reserved, bit 1 unsafe
  localparam logic [1:0] CLASS_ROM [128] = '{
    2,2,2,2,2,2,2,2, 2,2,2,2,2,2,2,2,
    2,2,2,2,2,2,2,2, 2,2,2,2,2,2,2,2,
    2,0,2,3,1,2,1,0, 0,0,0,1,1,0,0,1,
    0,0,0,0,0,0,0,0, 0,0,3,1,2,1,2,1,
    3,0,0,0,0,0,0,0, 0,0,0,0,0,0,0,0,
    0,0,0,0,0,0,0,0, 0,0,0,3,2,3,2,0,
    2,0,0,0,0,0,0,0, 0,0,0,0,0,0,0,0,
    0,0,0,0,0,0,0,0, 0,0,0,2,2,2,3,2
  };

  typedef enum logic [1:0] {
    MODE_NORMALIZE = 2'd0,
    MODE_ENCODE    = 2'd1,
    MODE_DECODE    = 2'd2
  } mode_t;

  typedef enum logic [1:0] {
    PEND_NONE  = 2'd0,
    PEND_PCT   = 2'd1,
    PEND_DIGIT = 2'd2
  } pend_t;

  // up to seven output bytes of one input item
  typedef struct packed {
    logic [SeqLen-1:0][7:0] bytes;
    logic [2:0]             cnt;
  } seq_t;

  typedef struct packed {
    seq_t seq;
    logic last;
    logic err;
  } cmd_t;

  typedef struct packed {
    logic empty;
    logic full;
  } q_stat_t;

  function automatic logic is_hex(logic [7:0] c);
    return (c >= CHR_0 && c <= CHR_9) || (c >= CHR_A && c <= CHR_F) ||
           (c >= CHR_LA && c <= CHR_LF);
  endfunction

  function automatic logic [3:0] hex_value(logic [7:0] c);
    logic [7:0] t;
    if (c >= CHR_0 && c <= CHR_9) t = c - CHR_0;
    else if (c >= CHR_LA && c <= CHR_LF) t = c - CHR_LA + HEX_TEN;
    else t = (c - CHR_A + HEX_TEN) & NIBBLE_MASK;
    return t[3:0];
  endfunction

  function automatic logic [7:0] hex_char(logic [3:0] v);
    logic [7:0] w;
    w = {4'd0, v};
    return (w < HEX_TEN) ? (w + CHR_0) : (w - HEX_TEN + CHR_A);
  endfunction

  function automatic logic needs_escape(logic [7:0] b);
    logic [1:0] cls;
    cls = b[7] ? CLS_U : CLASS_ROM[b[6:0]];
    return ((cls & CLS_U) != 2'b00) && ((cls & CLS_R) == 2'b00);
  endfunction

  function automatic seq_t seq_push(seq_t s, logic [7:0] b);
    seq_t r;
    r = s;
    r.bytes[s.cnt] = b;
    r.cnt = s.cnt + 3'd1;
    return r;
  endfunction

  function automatic seq_t seq_plain(seq_t s, logic [7:0] b);
    seq_t r;
    if (needs_escape(b)) begin
      r = seq_push(s, CHR_PCT);
      r = seq_push(r, hex_char(b[7:4]));
      r = seq_push(r, hex_char(b[3:0]));
    end else begin
      r = seq_push(s, b);
    end
    return r;
  endfunction

  function automatic seq_t seq_stray(seq_t s);
    seq_t r;
    r = seq_push(s, CHR_PCT);
    r = seq_push(r, CHR_2);
    r = seq_push(r, CHR_5);
    return r;
  endfunction

endpackage

// ===== design/upc_front.sv =====
// front end: accepts input bytes, tracks escape state, builds output byte lists
module upc_front import upc_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_byte,
  input  logic       in_last,
  input  logic       cfg_valid,
  input  logic [1:0] cfg_data,
  input  q_stat_t    q_stat,
  output logic       cmd_push,
  output cmd_t       cmd
);

  logic [1:0] mode_r;
  pend_t      pend_r, pend_nxt;
  logic [7:0] held_r, held_nxt;
  logic       disc_r, disc_nxt;
  logic       err;
  logic       fresh;
  logic       acc;
  seq_t       s;

  assign in_ready = !q_stat.full;
  assign acc      = in_valid && in_ready;

  always_comb begin
    s        = '0;
    pend_nxt = pend_r;
    held_nxt = held_r;
    disc_nxt = disc_r;
    err      = 1'b0;
    fresh    = 1'b0;
    unique case (mode_r)
      MODE_ENCODE: begin
        s = seq_plain('0, in_byte);
      end
      MODE_DECODE: begin
        if (disc_r) begin
          if (in_last) disc_nxt = 1'b0;
        end else begin
          if (pend_r == PEND_PCT) begin
            if (!is_hex(in_byte)) begin
              err = 1'b1;
            end else begin
              pend_nxt = PEND_DIGIT;
              held_nxt = in_byte;
            end
          end else if (pend_r == PEND_DIGIT) begin
            if (!is_hex(in_byte)) begin
              err = 1'b1;
            end else begin
              s        = seq_push('0, {hex_value(held_r), hex_value(in_byte)});
              pend_nxt = PEND_NONE;
              held_nxt = 8'd0;
            end
          end else if (in_byte == CHR_PCT) begin
            pend_nxt = PEND_PCT;
          end else begin
            pend_nxt = PEND_NONE;
            s        = seq_push('0, in_byte);
          end
          // string ends inside an escape
          if (in_last && pend_nxt != PEND_NONE) err = 1'b1;
          if (err) begin
            s        = seq_push('0, 8'd0);
            pend_nxt = PEND_NONE;
            held_nxt = 8'd0;
            disc_nxt = !in_last;
          end
        end
      end
      default: begin
        // normalize, also for the unused mode code
        if (pend_r == PEND_PCT) begin
          if (is_hex(in_byte)) begin
            pend_nxt = PEND_DIGIT;
            held_nxt = in_byte;
          end else begin
            pend_nxt = PEND_NONE;
            s        = seq_stray('0);
            fresh    = 1'b1;
          end
        end else if (pend_r == PEND_DIGIT) begin
          pend_nxt = PEND_NONE;
          held_nxt = 8'd0;
          if (is_hex(in_byte)) begin
            s = seq_push(seq_push(seq_push('0, CHR_PCT), held_r), in_byte);
          end else begin
            s     = seq_plain(seq_stray('0), held_r);
            fresh = 1'b1;
          end
        end else begin
          pend_nxt = PEND_NONE;
          fresh    = 1'b1;
        end
        if (fresh) begin
          if (in_byte == CHR_PCT) pend_nxt = PEND_PCT;
          else s = seq_plain(s, in_byte);
        end
        // flush a held percent and digit at string end
        if (in_last && pend_nxt != PEND_NONE) begin
          s = seq_stray(s);
          if (pend_nxt == PEND_DIGIT) s = seq_plain(s, held_nxt);
          pend_nxt = PEND_NONE;
          held_nxt = 8'd0;
        end
      end
    endcase
  end

  assign cmd.seq  = s;
  assign cmd.last = in_last || err;
  assign cmd.err  = err;
  assign cmd_push = acc && (s.cnt != 3'd0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_NORMALIZE;
      pend_r <= PEND_NONE;
      held_r <= 8'd0;
      disc_r <= 1'b0;
    end else if (cfg_valid) begin
      mode_r <= cfg_data;
      pend_r <= PEND_NONE;
      held_r <= 8'd0;
      disc_r <= 1'b0;
    end else if (acc) begin
      pend_r <= pend_nxt;
      held_r <= held_nxt;
      disc_r <= disc_nxt;
    end
  end

endmodule

// ===== design/upc_queue.sv =====
// two-entry command queue between front and back end
module upc_queue import upc_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    push,
  input  cmd_t    push_cmd,
  input  logic    pop,
  output cmd_t    head,
  output q_stat_t stat
);

  cmd_t       ent_r [2];
  logic       wr_ptr_r, rd_ptr_r;
  logic [1:0] cnt_r;

  assign head       = ent_r[rd_ptr_r];
  assign stat.empty = (cnt_r == 2'd0);
  assign stat.full  = (cnt_r == 2'd2);

  always_ff @(posedge clk) begin
    if (push) ent_r[wr_ptr_r] <= push_cmd;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      if (push) wr_ptr_r <= !wr_ptr_r;
      if (pop)  rd_ptr_r <= !rd_ptr_r;
      cnt_r <= cnt_r + {1'b0, push} - {1'b0, pop};
    end
  end

endmodule

// ===== design/upc_back.sv =====
// back end: walks the head command one byte a cycle, while out_ready allows, into the output register
module upc_back import upc_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  cmd_t       head,
  input  q_stat_t    q_stat,
  output logic       pop,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_byte,
  output logic       out_end,
  output logic       out_err
);

  logic [2:0] idx_r;
  logic       vld_r;
  logic [7:0] byte_r;
  logic       end_r, err_r;
  logic       load, at_end;

  assign load   = !q_stat.empty && (!vld_r || out_ready);
  assign at_end = (idx_r == head.seq.cnt - 3'd1);
  assign pop    = load && at_end;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
      idx_r <= 3'd0;
    end else begin
      if (load) begin
        vld_r <= 1'b1;
        idx_r <= at_end ? 3'd0 : idx_r + 3'd1;
      end else if (out_ready) begin
        vld_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      byte_r <= head.seq.bytes[idx_r];
      end_r  <= head.last && at_end;
      err_r  <= head.err;
    end
  end

  assign out_valid = vld_r;
  assign out_byte  = byte_r;
  assign out_end   = end_r;
  assign out_err   = err_r;

endmodule

// ===== design/url_percent_codec.sv =====
// top level of the url percent codec
// Rewrites a URL string streamed one byte per transfer, ending with tlast. The
// mode register selects normalize (0, also for code 3: keeps valid %XX, turns a
// stray % into %25, escapes unsafe non-reserved bytes), encode (1: escapes every
// unsafe non-reserved byte, % included) or decode (2: turns %XX into one byte).
// A malformed escape while decoding gives one error transfer (tuser high, data
// zero, tlast high) and the rest of that input string is dropped. Hex digits
// that the block writes are upper case; kept escapes keep their case. The
// front end takes one input byte per cycle while its two-entry command queue
// has room; the back end sends one output byte per cycle while out_tready is
// high. An input byte yields one output byte if plain, three if escaped, up
// to seven at a flushed escape. The back end's output rate sets the sustained
// rate. First output passes the command queue and the output register. A mode
// write clears the escape state; write it only while no string is in flight.
module url_percent_codec import upc_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  // input stream
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,   // [7:0] in_byte
  input  logic       in_tlast,   // in_last
  // result stream
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata,  // [7:0] out_byte
  output logic       out_tlast,  // out_end
  output logic       out_tuser,  // [0] out_error
  // mode register write
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [1:0] cfg_data    // [1:0] codec_mode
);

  cmd_t    push_cmd, head;
  logic    push, pop;
  q_stat_t q_stat;

  // mode writes are always taken
  assign cfg_ready = 1'b1;

  // front end: classify each byte and build its output byte list
  upc_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_ready (in_tready),
    .in_byte  (in_tdata),
    .in_last  (in_tlast),
    .cfg_valid(cfg_valid && cfg_ready),
    .cfg_data (cfg_data),
    .q_stat   (q_stat),
    .cmd_push (push),
    .cmd      (push_cmd)
  );

  // queue lets front and back end stall independently
  upc_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (push),
    .push_cmd(push_cmd),
    .pop     (pop),
    .head    (head),
    .stat    (q_stat)
  );

  // back end: one output transfer per cycle from the head command while out_tready is high
  upc_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .head     (head),
    .q_stat   (q_stat),
    .pop      (pop),
    .out_valid(out_tvalid),
    .out_ready(out_tready),
    .out_byte (out_tdata),
    .out_end  (out_tlast),
    .out_err  (out_tuser)
  );

endmodule

// ===== design/upc_checker.sv =====
// port-level assertions of the url percent codec and their bind
module upc_port_props (
  input logic       clk,
  input logic       rst_n,
  input logic       out_tvalid,
  input logic       out_tready,
  input logic [7:0] out_tdata,
  input logic       out_tlast,
  input logic       out_tuser
);

  // stalled result transfer stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("out_tvalid dropped while stalled");

  // stalled result keeps its payload
  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=>
      $stable(out_tdata) && $stable(out_tlast) && $stable(out_tuser))
    else $error("result payload changed while stalled");

  // error item carries zero data and ends the string
  a_err_item: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |-> out_tdata == 8'd0 && out_tlast)
    else $error("malformed error item");

  // reset empties the output side
  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("output valid right after reset");

endmodule

bind url_percent_codec upc_port_props u_upc_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_tvalid(out_tvalid),
  .out_tready(out_tready),
  .out_tdata (out_tdata),
  .out_tlast (out_tlast),
  .out_tuser (out_tuser)
);

// ===== dv/upc_checker.sv =====
`timescale 1ns / 100ps
// checker of the url percent codec: predicts each string's output and compares every result transfer
module upc_checker import upc_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  input  logic       in_tready,
  input  logic [7:0] in_tdata,
  input  logic       in_tlast,
  input  logic       out_tvalid,
  input  logic       out_tready,
  input  logic [7:0] out_tdata,
  input  logic       out_tlast,
  input  logic       out_tuser,
  input  logic       cfg_valid,
  input  logic       cfg_ready,
  input  logic [1:0] cfg_data,
  output int         fail_count,
  output int         pending,
  output int         result_count,
  output int         error_count
);

  typedef struct packed {
    logic [7:0] data;
    logic       last;
    logic       err;
  } url_out_t;

  url_out_t   expected_q[$];
  logic [7:0] step_q[$];
  logic       step_err;

  logic [1:0] mode;
  pend_t      pend;
  logic [7:0] held;
  logic       dropping;

  int fails = 0;
  int results = 0;
  int errs = 0;

  function automatic logic hex_digit_ok(logic [7:0] c);
    return (c >= CHR_0 && c <= CHR_9) || (c >= CHR_A && c <= CHR_F) ||
           (c >= CHR_LA && c <= CHR_LF);
  endfunction

  // letters of either case carry their value minus nine in the low nibble
  function automatic logic [3:0] nibble_of(logic [7:0] c);
    return (c <= CHR_9) ? c[3:0] : c[3:0] + 4'd9;
  endfunction

  function automatic logic [7:0] nibble_chr(logic [3:0] v);
    return (v < 4'd10) ? CHR_0 + {4'd0, v} : CHR_A + {4'd0, v} - 8'd10;
  endfunction

  // unsafe and not reserved
  function automatic logic must_escape(logic [7:0] b);
    logic [1:0] cls;
    cls = b[7] ? CLS_U : CLASS_ROM[b[6:0]];
    return cls == CLS_U;
  endfunction

  task push_plain(input logic [7:0] b);
    if (must_escape(b)) begin
      step_q.push_back(CHR_PCT);
      step_q.push_back(nibble_chr(b[7:4]));
      step_q.push_back(nibble_chr(b[3:0]));
    end else begin
      step_q.push_back(b);
    end
  endtask

  task push_stray();
    step_q.push_back(CHR_PCT);
    step_q.push_back(CHR_2);
    step_q.push_back(CHR_5);
  endtask

  task fresh_byte(input logic [7:0] b);
    if (b == CHR_PCT) pend = PEND_PCT;
    else push_plain(b);
  endtask

  task normalize_step(input logic [7:0] b, input logic last);
    logic [7:0] h;
    case (pend)
      PEND_PCT: begin
        if (hex_digit_ok(b)) begin
          pend = PEND_DIGIT;
          held = b;
        end else begin
          pend = PEND_NONE;
          push_stray();
          fresh_byte(b);
        end
      end
      PEND_DIGIT: begin
        h = held;
        pend = PEND_NONE;
        held = 8'h00;
        if (hex_digit_ok(b)) begin
          step_q.push_back(CHR_PCT);
          step_q.push_back(h);
          step_q.push_back(b);
        end else begin
          push_stray();
          push_plain(h);
          fresh_byte(b);
        end
      end
      default: begin
        pend = PEND_NONE;
        fresh_byte(b);
      end
    endcase
    // flush of an escape left open at the string end
    if (last && pend != PEND_NONE) begin
      push_stray();
      if (pend == PEND_DIGIT) push_plain(held);
      pend = PEND_NONE;
      held = 8'h00;
    end
  endtask

  task decode_fail(input logic last);
    step_err = 1'b1;
    pend = PEND_NONE;
    held = 8'h00;
    dropping = !last;
  endtask

  task decode_step(input logic [7:0] b, input logic last);
    if (dropping) begin
      if (last) dropping = 1'b0;
    end else begin
      case (pend)
        PEND_PCT: begin
          if (!hex_digit_ok(b)) begin
            decode_fail(last);
          end else begin
            pend = PEND_DIGIT;
            held = b;
          end
        end
        PEND_DIGIT: begin
          if (!hex_digit_ok(b)) begin
            decode_fail(last);
          end else begin
            step_q.push_back({nibble_of(held), nibble_of(b)});
            pend = PEND_NONE;
            held = 8'h00;
          end
        end
        default: begin
          if (b == CHR_PCT) pend = PEND_PCT;
          else step_q.push_back(b);
        end
      endcase
      if (!step_err && last && pend != PEND_NONE) decode_fail(last);
    end
  endtask

  task predict_results(input logic [7:0] b, input logic last);
    url_out_t item;
    step_q.delete();
    step_err = 1'b0;
    if (mode == MODE_DECODE) decode_step(b, last);
    else if (mode == MODE_ENCODE) push_plain(b);
    else normalize_step(b, last);
    if (step_err) begin
      item = '{data: 8'h00, last: 1'b1, err: 1'b1};
      expected_q.push_back(item);
    end else begin
      foreach (step_q[i]) begin
        item = '{data: step_q[i], last: last && (i == step_q.size() - 1), err: 1'b0};
        expected_q.push_back(item);
      end
    end
  endtask

  task clear_escape();
    pend = PEND_NONE;
    held = 8'h00;
    dropping = 1'b0;
  endtask

  always @(posedge clk) begin
    url_out_t want;
    if (!rst_n) begin
      mode = MODE_NORMALIZE;
      clear_escape();
      expected_q.delete();
    end else begin
      if (out_tvalid && out_tready) begin
        results++;
        if (out_tuser) errs++;
        if (expected_q.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual data %h last %b error %b",
                   $time, out_tdata, out_tlast, out_tuser);
          fails++;
        end else begin
          want = expected_q.pop_front();
          if (want.data !== out_tdata || want.last !== out_tlast || want.err !== out_tuser) begin
            $display("%0t: mismatch, expected data %h last %b error %b, actual data %h last %b error %b",
                     $time, want.data, want.last, want.err, out_tdata, out_tlast, out_tuser);
            fails++;
          end
        end
      end
      if (cfg_valid && cfg_ready) begin
        mode = cfg_data;
        clear_escape();
      end
      if (in_tvalid && in_tready) predict_results(in_tdata, in_tlast);
    end
    pending <= expected_q.size();
    fail_count <= fails;
    result_count <= results;
    error_count <= errs;
  end

endmodule

// ===== dv/testbench.sv =====
`timescale 1ns / 100ps
// top of the url percent codec testbench: clock, reset, stimulus and verdict
module testbench;
  import upc_pkg::*;

  // code 3 is unused by the block and must behave as normalize
  localparam logic [1:0] MODE_SPARE = 2'd3;

  // receiver stall patterns
  localparam int RX_OPEN     = 0;
  localparam int RX_COIN     = 1;
  localparam int RX_PERIODIC = 2;
  localparam int RX_BURSTY   = 3;

  localparam int PHASE_ITEMS = 45;
  localparam int DRAIN_WAIT  = 8;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_tvalid = 1'b0;
  logic       in_tready;
  logic [7:0] in_tdata = 8'h00;
  logic       in_tlast = 1'b0;
  logic       out_tvalid;
  logic       out_tready = 1'b0;
  logic [7:0] out_tdata;
  logic       out_tlast;
  logic       out_tuser;
  logic       cfg_valid = 1'b0;
  logic       cfg_ready;
  logic [1:0] cfg_data = 2'd0;

  int fail_count;
  int pending;
  int result_count;
  int error_count;

  // sender pacing
  int items_sent = 0;
  int mode_writes = 0;
  int burst_left = 0;
  int tx_gap_max = 0;

  // receiver pacing
  int   rx_style = RX_OPEN;
  int   rx_tick = 0;
  int   rx_hold = 0;
  logic rx_level = 1'b1;

  logic [7:0] text_q[$];

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  url_percent_codec DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data)
  );

  upc_checker u_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_tvalid    (in_tvalid),
    .in_tready    (in_tready),
    .in_tdata     (in_tdata),
    .in_tlast     (in_tlast),
    .out_tvalid   (out_tvalid),
    .out_tready   (out_tready),
    .out_tdata    (out_tdata),
    .out_tlast    (out_tlast),
    .out_tuser    (out_tuser),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_data     (cfg_data),
    .fail_count   (fail_count),
    .pending      (pending),
    .result_count (result_count),
    .error_count  (error_count)
  );

  // result side backpressure, pattern picked per phase
  always @(posedge clk) begin
    case (rx_style)
      RX_OPEN: out_tready <= 1'b1;
      RX_COIN: out_tready <= ($urandom_range(0, 1) == 1);
      RX_PERIODIC: begin
        rx_tick++;
        out_tready <= (rx_tick % 4) != 3;
      end
      default: begin
        // long stalls alternating with short open windows
        if (rx_hold == 0) begin
          rx_level = !rx_level;
          rx_hold = rx_level ? $urandom_range(1, 8) : $urandom_range(1, 20);
        end else begin
          rx_hold--;
        end
        out_tready <= rx_level;
      end
    endcase
  end

  // one input transfer; a random gap opens each new burst
  task send_item(input logic [7:0] b, input logic last);
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(0, tx_gap_max);
      if (gap > 0) begin
        in_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 12);
    end
    in_tvalid <= 1'b1;
    in_tdata <= b;
    in_tlast <= last;
    do @(posedge clk); while (!in_tready);
    burst_left--;
    items_sent++;
  endtask

  task send_text(input string s, input logic close);
    for (int i = 0; i < s.len(); i++) send_item(s[i], close && (i == s.len() - 1));
  endtask

  // wait for every expected result, then let the block go quiet
  task settle();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
  endtask

  task write_mode(input logic [1:0] m);
    cfg_valid <= 1'b1;
    cfg_data <= m;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    mode_writes++;
  endtask

  function automatic logic [7:0] rand_hex_digit();
    int v;
    v = $urandom_range(0, 15);
    if (v < 10) return CHR_0 + 8'(v);
    return (($urandom_range(0, 1) == 1) ? CHR_A : CHR_LA) + 8'(v) - 8'd10;
  endfunction

  // one piece of a url: mostly well-formed, some stray escapes and noise
  task add_token();
    int roll;
    logic [7:0] c;
    roll = $urandom_range(0, 99);
    if (roll < 35) begin
      case ($urandom_range(0, 2))
        0: c = 8'($urandom_range(CHR_LA, 8'h7a));
        1: c = 8'($urandom_range(CHR_A, 8'h5a));
        default: c = 8'($urandom_range(CHR_0, CHR_9));
      endcase
      text_q.push_back(c);
    end else if (roll < 50) begin
      c = 8'($urandom_range(8'h20, 8'h7e));
      text_q.push_back(c);
    end else if (roll < 75) begin
      text_q.push_back(CHR_PCT);
      text_q.push_back(rand_hex_digit());
      text_q.push_back(rand_hex_digit());
    end else if (roll < 83) begin
      // percent with one digit, then anything
      text_q.push_back(CHR_PCT);
      text_q.push_back(rand_hex_digit());
      c = 8'($urandom_range(8'h20, 8'h7e));
      text_q.push_back(c);
    end else if (roll < 93) begin
      c = 8'($urandom_range(0, 255));
      text_q.push_back(c);
    end else begin
      // lone percent, may land at the string end
      text_q.push_back(CHR_PCT);
    end
  endtask

  task send_random_string();
    int tokens;
    text_q.delete();
    tokens = $urandom_range(1, 6);
    repeat (tokens) add_token();
    foreach (text_q[i]) send_item(text_q[i], i == text_q.size() - 1);
  endtask

  logic [1:0] phase_modes [8] = '{MODE_NORMALIZE, MODE_DECODE, MODE_ENCODE, MODE_DECODE,
                                  MODE_SPARE, MODE_NORMALIZE, MODE_DECODE, MODE_ENCODE};

  initial begin
    int phase_start;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed part, no idling
    tx_gap_max = 0;
    rx_style = RX_OPEN;
    write_mode(MODE_NORMALIZE);
    send_text("%4a", 1'b1);          // valid escape kept, lower case digit
    send_text("%%4", 1'b1);          // stray percent, then flush of percent and digit
    send_item(8'h00, 1'b0);          // byte extremes, both escaped
    send_item(8'hff, 1'b0);
    send_text(" #", 1'b1);           // unsafe space escaped, reserved hash kept
    send_text("x%", 1'b0);           // string left open on a held percent
    settle();
    write_mode(MODE_SPARE);          // unused code, abandons the open string
    send_text("%", 1'b1);            // lone percent at the end flushes as %25
    settle();
    write_mode(MODE_ENCODE);
    send_text("%~", 1'b1);
    settle();
    write_mode(MODE_DECODE);
    send_text("%7e", 1'b1);          // decodes to one byte
    send_text("%4", 1'b1);           // string ends inside an escape
    send_text("%gab", 1'b1);         // bad digit, rest dropped, last byte gives nothing
    send_text("%A", 1'b0);           // escape left open across a mode write
    settle();

    // random phases over all mode codes, with idling patterns picked at random
    foreach (phase_modes[p]) begin
      write_mode(phase_modes[p]);
      rx_style = $urandom_range(RX_OPEN, RX_BURSTY);
      tx_gap_max = ($urandom_range(0, 2) == 0) ? 0 : 6;
      phase_start = items_sent;
      while (items_sent - phase_start < PHASE_ITEMS) send_random_string();
      settle();
    end

    repeat (20) @(posedge clk);
    $display("run covered %0d input transfers over %0d mode writes, all four mode codes",
             items_sent, mode_writes);
    $display("%0d result transfers compared, %0d of them decode error items",
             result_count, error_count);
    if (fail_count == 0 && pending == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  // watchdog, far above the slowest legal run
  initial begin
    #5_000_000;
    $display("timeout with %0d results still expected", pending);
    $display("TB_ERROR");
    $finish;
  end

endmodule
